// ===== hdl/ylt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ylt_pkg: shared types and constants of the yaml line tokenizer
// Record layout, record bundles passed from scanner to output side, and
// saturating counter helpers.
// ----------------------------------------------------------------------------
package ylt_pkg;

    localparam int COLUMN_LIMIT = 255;
    localparam int LENGTH_LIMIT = 4095;
    localparam int QUEUE_DEPTH  = 4;
    localparam int BUNDLE_SIZE  = 3;
    localparam int TDATA_W      = 40;

    // byte codes the scanner looks for
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_LBRACE = 8'h7b;

    typedef enum logic [1:0] {
        KIND_BARE   = 2'd0,
        KIND_QUOTED = 2'd1,
        KIND_LINE   = 2'd2,
        KIND_FILE   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  spaces;
        logic [7:0]  column;
        logic [11:0] length;
        logic        colon;
        logic [7:0]  follow;
        logic        unclosed;
        logic        last;
    } t_rec;

    // up to three records caused by one input byte
    typedef struct packed {
        logic [1:0]                  cnt;
        t_rec [BUNDLE_SIZE-1:0]      recs;
    } t_bundle;

    function automatic logic [7:0] sat_col(input logic [7:0] v);
        logic [7:0] r;
        if (32'(v) >= COLUMN_LIMIT) begin
            r = 8'(COLUMN_LIMIT);
        end else begin
            r = v + 8'd1;
        end
        return r;
    endfunction

    function automatic logic [11:0] sat_len(input logic [11:0] v);
        logic [11:0] r;
        if (32'(v) >= LENGTH_LIMIT) begin
            r = 12'(LENGTH_LIMIT);
        end else begin
            r = v + 12'd1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ylt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ylt_front: byte scanner
// Classifies each byte, keeps the token and line state, and builds the
// bundle of records that the byte causes.
// ----------------------------------------------------------------------------
module ylt_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_end,
    input  wire logic             i_space_ok,
    output logic                  o_ready,
    output logic                  o_push,
    output ylt_pkg::t_bundle      o_bundle
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_BARE  = 3'd1,
        MODE_TAG   = 3'd2,
        MODE_QUOTE = 3'd3,
        MODE_HELD  = 3'd4
    } t_mode;

    t_mode       r_mode,   n_mode;
    logic [7:0]  r_space,  n_space;
    logic [7:0]  r_column, n_column;
    logic [7:0]  r_tstart, n_tstart;
    logic [11:0] r_len,    n_len;
    logic        r_pwc,    n_pwc;
    logic        r_pending, n_pending;
    logic        r_lstart, n_lstart;

    ylt_pkg::t_rec tk, ln, fl;
    logic          v_tk, v_ln, v_fl;
    logic          do_idle;
    logic [7:0]    sc_in;
    logic          is_break;
    logic          accept;
    logic [11:0]   len_a;

    assign o_ready  = i_space_ok;
    assign accept   = i_valid && i_space_ok;
    assign is_break = (i_byte == ylt_pkg::CH_LF) || (i_byte == ylt_pkg::CH_NUL);

    // next state and candidate records
    always_comb begin
        n_mode    = r_mode;
        n_space   = r_space;
        n_column  = r_column;
        n_tstart  = r_tstart;
        n_len     = r_len;
        n_pwc     = r_pwc;
        n_pending = r_pending;
        n_lstart  = r_lstart;
        v_tk      = 1'b0;
        v_ln      = 1'b0;
        v_fl      = 1'b0;
        do_idle   = 1'b0;
        sc_in     = r_space;
        len_a     = r_len;

        tk          = '0;
        tk.kind     = ((r_mode == MODE_QUOTE) || ((r_mode == MODE_HELD) && r_pending))
                      ? ylt_pkg::KIND_QUOTED : ylt_pkg::KIND_BARE;
        tk.spaces   = r_space;
        tk.column   = r_tstart;
        tk.length   = r_len;
        tk.colon    = (r_mode == MODE_BARE) && r_pwc;
        ln          = '0;
        ln.kind     = ylt_pkg::KIND_LINE;
        fl          = '0;
        fl.kind     = ylt_pkg::KIND_FILE;

        if (i_end) begin
            // flush open token, unfinished line, then file end
            v_tk        = (r_mode != MODE_IDLE);
            tk.unclosed = (r_mode == MODE_QUOTE);
            v_ln        = r_lstart;
            ln.spaces   = v_tk ? 8'd0 : r_space;
            ln.column   = r_column;
            v_fl        = 1'b1;
            n_mode      = MODE_IDLE;
            n_space     = '0;
            n_column    = '0;
            n_tstart    = '0;
            n_len       = '0;
            n_pwc       = 1'b0;
            n_pending   = 1'b0;
            n_lstart    = 1'b0;
        end else begin
            n_column = ylt_pkg::sat_col(r_column);
            unique case (r_mode)
                MODE_BARE, MODE_TAG: begin
                    if (is_break || (i_byte == ylt_pkg::CH_SPACE)) begin
                        v_tk      = 1'b1;
                        tk.follow = i_byte;
                        do_idle   = 1'b1;
                        sc_in     = '0;
                    end else if (r_mode == MODE_TAG) begin
                        n_len = ylt_pkg::sat_len(r_len);
                    end else begin
                        // a held colon turns into content when more follows
                        len_a = r_pwc ? ylt_pkg::sat_len(r_len) : r_len;
                        n_pwc = (i_byte == ylt_pkg::CH_COLON);
                        n_len = n_pwc ? len_a : ylt_pkg::sat_len(len_a);
                    end
                end
                MODE_QUOTE: begin
                    if (i_byte == ylt_pkg::CH_QUOTE) begin
                        n_mode    = MODE_HELD;
                        n_pending = 1'b1;
                        n_lstart  = 1'b1;
                    end else begin
                        n_len = ylt_pkg::sat_len(r_len);
                        if (is_break) begin
                            n_column = '0;
                            n_lstart = 1'b0;
                        end else begin
                            n_lstart = 1'b1;
                        end
                    end
                end
                MODE_HELD: begin
                    v_tk      = 1'b1;
                    tk.follow = i_byte;
                    do_idle   = 1'b1;
                    sc_in     = '0;
                end
                default: begin
                    n_mode  = MODE_IDLE;
                    do_idle = 1'b1;
                    sc_in   = r_space;
                end
            endcase

            // token just emitted: clear token state
            if (v_tk) begin
                n_mode    = MODE_IDLE;
                n_space   = '0;
                n_len     = '0;
                n_pwc     = 1'b0;
                n_pending = 1'b0;
            end

            // byte seen between tokens
            if (do_idle) begin
                if (is_break) begin
                    v_ln      = 1'b1;
                    ln.spaces = sc_in;
                    ln.column = r_column;
                    n_space   = '0;
                    n_column  = '0;
                    n_lstart  = 1'b0;
                end else begin
                    n_lstart = 1'b1;
                    priority if (i_byte == ylt_pkg::CH_SPACE) begin
                        n_space = ylt_pkg::sat_col(sc_in);
                    end else if ((i_byte == ylt_pkg::CH_LBRACK) ||
                                 (i_byte == ylt_pkg::CH_LBRACE)) begin
                        n_mode    = MODE_HELD;
                        n_pending = 1'b0;
                        n_tstart  = r_column;
                        n_len     = 12'd1;
                    end else if (i_byte == ylt_pkg::CH_QUOTE) begin
                        n_mode   = MODE_QUOTE;
                        n_tstart = ylt_pkg::sat_col(r_column);
                        n_len    = '0;
                    end else if (i_byte == ylt_pkg::CH_BANG) begin
                        n_mode   = MODE_TAG;
                        n_tstart = r_column;
                        n_len    = 12'd1;
                    end else begin
                        n_mode   = MODE_BARE;
                        n_tstart = r_column;
                        n_pwc    = (i_byte == ylt_pkg::CH_COLON);
                        n_len    = n_pwc ? 12'd0 : 12'd1;
                    end
                end
            end
        end

        tk.last = !v_ln && !v_fl;
        ln.last = !v_fl;
        fl.last = 1'b1;
    end

    // pack candidates into the bundle in order
    always_comb begin
        o_bundle         = '0;
        o_bundle.cnt     = 2'(v_tk) + 2'(v_ln) + 2'(v_fl);
        o_bundle.recs[0] = v_tk ? tk : (v_ln ? ln : fl);
        o_bundle.recs[1] = v_tk ? (v_ln ? ln : fl) : fl;
        o_bundle.recs[2] = fl;
    end

    assign o_push = accept && (o_bundle.cnt != 2'd0);

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_space   <= '0;
            r_column  <= '0;
            r_tstart  <= '0;
            r_len     <= '0;
            r_pwc     <= 1'b0;
            r_pending <= 1'b0;
            r_lstart  <= 1'b0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_space   <= n_space;
            r_column  <= n_column;
            r_tstart  <= n_tstart;
            r_len     <= n_len;
            r_pwc     <= n_pwc;
            r_pending <= n_pending;
            r_lstart  <= n_lstart;
        end
    end

    // a pushed bundle marks exactly its final record as last
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_bundle.recs[o_bundle.cnt - 2'd1].last)
        else $error("final record of bundle not marked last");

endmodule
`default_nettype wire

// ===== hdl/ylt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ylt_queue: bundle queue
// Short first-in first-out store of record bundles between scanner and
// output serialiser.
// ----------------------------------------------------------------------------
module ylt_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ylt_pkg::t_bundle  i_bundle,
    input  wire logic              i_pop,
    output logic                   o_space_ok,
    output logic                   o_valid,
    output ylt_pkg::t_bundle       o_head
);

    localparam int PTR_W = $clog2(ylt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ylt_pkg::QUEUE_DEPTH + 1);

    ylt_pkg::t_bundle r_mem [ylt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_space_ok = (r_count != CNT_W'(ylt_pkg::QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_space_ok || i_pop))
        else $error("bundle pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== hdl/ylt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ylt_back: record serialiser
// Walks the records of the head bundle one per cycle, while the receiver is
// ready, into the output register and pops the bundle as its last record loads.
// ----------------------------------------------------------------------------
module ylt_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire ylt_pkg::t_bundle  i_q_head,
    output logic                   o_q_pop,
    input  wire logic              i_tready,
    output logic                   o_tvalid,
    output ylt_pkg::t_rec          o_rec
);

    logic [1:0]    r_idx;
    logic          r_valid;
    ylt_pkg::t_rec r_rec;
    logic          load;
    logic          at_end;

    assign load    = i_q_valid && (!r_valid || i_tready);
    assign at_end  = (r_idx == (i_q_head.cnt - 2'd1));
    assign o_q_pop = load && at_end;

    // record index within the head bundle and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= at_end ? 2'd0 : (r_idx + 2'd1);
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_q_head.recs[r_idx];
        end
    end

    assign o_tvalid = r_valid;
    assign o_rec    = r_rec;

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx < i_q_head.cnt))
        else $error("record index beyond head bundle");

endmodule
`default_nettype wire

// ===== hdl/yaml_line_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A record passes through the bundle queue and the output register before it is presented.
// Throughput: while the receiver is ready, one byte per cycle while bytes cause
// at most one record each; the output register sends one record per cycle, so
// a byte causing 2 or 3 records sends them one by one, absorbed by a 4-bundle queue.
// Reset: synchronous active-low i_rst_n returns the scanner to idle between
// tokens with all counters zero, and empties the queue and output register.
// ----------------------------------------------------------------------------
// yaml_line_tokenizer: byte stream to token record converter
// Scanner front end, bundle queue, and record serialiser driving a stream
// output.
// ----------------------------------------------------------------------------
module yaml_line_tokenizer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,  // [7:0] byte_in
    input  wire logic                          i_s_tlast,  // stream_end
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [7:0] leading_spaces, [15:8] start_column, [27:16] token_length,
    // [28] key_colon, [36:29] following_byte, [37] unclosed_quote
    output logic [ylt_pkg::TDATA_W-1:0]        o_m_tdata,
    output logic [1:0]                         o_m_tuser,  // [1:0] token_kind
    output logic                               o_m_tlast   // last_of_run
);

    logic             space_ok;
    logic             push;
    ylt_pkg::t_bundle bundle;
    logic             q_valid;
    ylt_pkg::t_bundle q_head;
    logic             q_pop;
    ylt_pkg::t_rec    rec;

    // scanner
    ylt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .i_byte     (i_s_tdata),
        .i_end      (i_s_tlast),
        .i_space_ok (space_ok),
        .o_ready    (o_s_tready),
        .o_push     (push),
        .o_bundle   (bundle)
    );

    // bundle queue
    ylt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_bundle   (bundle),
        .i_pop      (q_pop),
        .o_space_ok (space_ok),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    // serialiser
    ylt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_tready  (i_m_tready),
        .o_tvalid  (o_m_tvalid),
        .o_rec     (rec)
    );

    // output packing
    assign o_m_tdata = {2'b00, rec.unclosed, rec.follow, rec.colon, rec.length,
                        rec.column, rec.spaces};
    assign o_m_tuser = rec.kind;
    assign o_m_tlast = rec.last;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: yaml line tokenizer self-checking bench
// Drives byte requests from a queue, keeps a behavioural scanner that works
// out the token records each accepted byte should produce, and compares
// every record leaving the block against the oldest outstanding one.
// ----------------------------------------------------------------------------
module testbench;

    // scanner states of the behavioural model
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_BARE,
        SCAN_TAG,
        SCAN_QUOTE,
        SCAN_HELD
    } t_scan_state;

    typedef struct packed {
        ylt_pkg::t_kind kind;
        logic [7:0]     spaces;
        logic [7:0]     column;
        logic [11:0]    length;
        logic           colon;
        logic [7:0]     follow;
        logic           unclosed;
        logic           last;
    } t_token_rec;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata = 8'd0;   // [7:0] byte_in
    logic                          i_s_tlast = 1'b0;   // stream_end
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    // [7:0] leading_spaces, [15:8] start_column, [27:16] token_length,
    // [28] key_colon, [36:29] following_byte, [37] unclosed_quote
    logic [ylt_pkg::TDATA_W-1:0]   o_m_tdata;
    logic [1:0]                    o_m_tuser;          // [1:0] token_kind
    logic                          o_m_tlast;          // last_of_run

    // pending byte requests: bit 8 marks end of stream
    logic [8:0]           byte_q[$];
    t_token_rec           expected_recs[$];
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   fail_count = 0;

    // behavioural scanner state
    t_scan_state          scan_state = SCAN_IDLE;
    int unsigned          space_run = 0;
    int unsigned          line_col = 0;
    int unsigned          tok_col = 0;
    int unsigned          tok_len = 0;
    bit                   colon_seen = 1'b0;
    bit                   held_quote = 1'b0;
    bit                   line_open = 1'b0;
    t_token_rec           staged_rec;
    bit                   rec_staged = 1'b0;
    t_token_rec           wanted;
    logic [8:0]           next_req;

    yaml_line_tokenizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned clip_col(input int unsigned v);
        return (v > ylt_pkg::COLUMN_LIMIT) ? ylt_pkg::COLUMN_LIMIT : v;
    endfunction

    function automatic int unsigned clip_len(input int unsigned v);
        return (v > ylt_pkg::LENGTH_LIMIT) ? ylt_pkg::LENGTH_LIMIT : v;
    endfunction

    // records of one byte are staged so the final one can carry the last flag
    task stage_rec(input ylt_pkg::t_kind kind, input int unsigned sp,
                   input int unsigned col, input int unsigned len, input bit colon,
                   input logic [7:0] follow, input bit unclosed);
        if (rec_staged) begin
            expected_recs.push_back(staged_rec);
        end
        staged_rec.kind     = kind;
        staged_rec.spaces   = sp[7:0];
        staged_rec.column   = col[7:0];
        staged_rec.length   = len[11:0];
        staged_rec.colon    = colon;
        staged_rec.follow   = follow;
        staged_rec.unclosed = unclosed;
        staged_rec.last     = 1'b0;
        rec_staged          = 1'b1;
    endtask

    // emit the open or held token and go back between tokens
    task close_token(input logic [7:0] follow, input bit unclosed);
        ylt_pkg::t_kind kind;
        bit             colon;
        kind = ylt_pkg::KIND_BARE;
        if (scan_state == SCAN_QUOTE || (scan_state == SCAN_HELD && held_quote)) begin
            kind = ylt_pkg::KIND_QUOTED;
        end
        colon = (scan_state == SCAN_BARE) ? colon_seen : 1'b0;
        stage_rec(kind, space_run, tok_col, tok_len, colon, follow, unclosed);
        space_run  = 0;
        tok_len    = 0;
        colon_seen = 1'b0;
        held_quote = 1'b0;
        scan_state = SCAN_IDLE;
    endtask

    // byte seen between tokens: line end, space, or start of a token
    task scan_between(input logic [7:0] b, input int unsigned c);
        if (b == ylt_pkg::CH_LF || b == ylt_pkg::CH_NUL) begin
            stage_rec(ylt_pkg::KIND_LINE, space_run, c, 0, 1'b0, 8'd0, 1'b0);
            space_run = 0;
            line_col  = 0;
            line_open = 1'b0;
        end else begin
            line_open = 1'b1;
            if (b == ylt_pkg::CH_SPACE) begin
                space_run = clip_col(space_run + 1);
            end else if (b == ylt_pkg::CH_LBRACK || b == ylt_pkg::CH_LBRACE) begin
                scan_state = SCAN_HELD;
                held_quote = 1'b0;
                tok_col    = c;
                tok_len    = 1;
            end else if (b == ylt_pkg::CH_QUOTE) begin
                scan_state = SCAN_QUOTE;
                tok_col    = clip_col(c + 1);
                tok_len    = 0;
            end else if (b == ylt_pkg::CH_BANG) begin
                scan_state = SCAN_TAG;
                tok_col    = c;
                tok_len    = 1;
            end else begin
                scan_state = SCAN_BARE;
                tok_col    = c;
                colon_seen = (b == ylt_pkg::CH_COLON);
                tok_len    = colon_seen ? 0 : 1;
            end
        end
    endtask

    // work out the records one accepted request should produce
    task tokenize(input logic [7:0] b, input bit fin);
        int unsigned c;
        if (fin) begin
            if (scan_state == SCAN_QUOTE) begin
                close_token(8'd0, 1'b1);
            end else if (scan_state != SCAN_IDLE) begin
                close_token(8'd0, 1'b0);
            end
            if (line_open) begin
                stage_rec(ylt_pkg::KIND_LINE, space_run, line_col, 0, 1'b0, 8'd0, 1'b0);
            end
            stage_rec(ylt_pkg::KIND_FILE, 0, 0, 0, 1'b0, 8'd0, 1'b0);
            scan_state = SCAN_IDLE;
            space_run  = 0;
            line_col   = 0;
            tok_col    = 0;
            tok_len    = 0;
            colon_seen = 1'b0;
            held_quote = 1'b0;
            line_open  = 1'b0;
        end else begin
            c = line_col;
            line_col = clip_col(line_col + 1);
            case (scan_state)
                SCAN_BARE, SCAN_TAG: begin
                    if (b == ylt_pkg::CH_SPACE || b == ylt_pkg::CH_LF ||
                        b == ylt_pkg::CH_NUL) begin
                        close_token(b, 1'b0);
                        scan_between(b, c);
                    end else if (scan_state == SCAN_TAG) begin
                        tok_len = clip_len(tok_len + 1);
                    end else begin
                        // a colon only counts once something follows it
                        if (colon_seen) begin
                            tok_len = clip_len(tok_len + 1);
                        end
                        colon_seen = (b == ylt_pkg::CH_COLON);
                        if (!colon_seen) begin
                            tok_len = clip_len(tok_len + 1);
                        end
                    end
                end
                SCAN_QUOTE: begin
                    if (b == ylt_pkg::CH_QUOTE) begin
                        scan_state = SCAN_HELD;
                        held_quote = 1'b1;
                        line_open  = 1'b1;
                    end else begin
                        tok_len = clip_len(tok_len + 1);
                        if (b == ylt_pkg::CH_LF || b == ylt_pkg::CH_NUL) begin
                            line_col  = 0;
                            line_open = 1'b0;
                        end else begin
                            line_open = 1'b1;
                        end
                    end
                end
                SCAN_HELD: begin
                    close_token(b, 1'b0);
                    scan_between(b, c);
                end
                default: begin
                    scan_between(b, c);
                end
            endcase
        end
        if (rec_staged) begin
            staged_rec.last = 1'b1;
            expected_recs.push_back(staged_rec);
            rec_staged = 1'b0;
        end
    endtask

    task push_byte(input logic [7:0] b);
        byte_q.push_back({1'b0, b});
    endtask

    // end of stream, with a random byte that the block must ignore
    task push_end;
        byte_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    task push_word(input int n);
        int roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                push_byte(ylt_pkg::CH_COLON);
            end else if (roll < 16) begin
                push_byte(8'($urandom_range(48, 57)));
            end else begin
                push_byte(8'($urandom_range(97, 122)));
            end
        end
    endtask

    // one mostly well-formed line: indent, a few tokens, line end
    task push_random_line;
        int          roll;
        logic [7:0]  b;
        repeat ($urandom_range(0, 4)) push_byte(ylt_pkg::CH_SPACE);
        repeat ($urandom_range(1, 4)) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                push_word($urandom_range(1, 6));
                push_byte(ylt_pkg::CH_COLON);
            end else if (roll < 43) begin
                push_word($urandom_range(1, 6));
            end else if (roll < 58) begin
                push_byte(ylt_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 6)) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 10) begin
                        b = ylt_pkg::CH_LF;
                    end else if (roll < 15) begin
                        b = ylt_pkg::CH_NUL;
                    end else if (roll < 25) begin
                        b = ylt_pkg::CH_SPACE;
                    end else if (roll < 45) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == ylt_pkg::CH_QUOTE) begin
                            b = ylt_pkg::CH_COLON;
                        end
                    end else begin
                        b = 8'($urandom_range(97, 122));
                    end
                    push_byte(b);
                end
                if ($urandom_range(0, 19) == 0) begin
                    push_end;
                    return;
                end
                push_byte(ylt_pkg::CH_QUOTE);
            end else if (roll < 70) begin
                push_byte($urandom_range(0, 1) ? ylt_pkg::CH_LBRACK : ylt_pkg::CH_LBRACE);
            end else if (roll < 80) begin
                push_byte(ylt_pkg::CH_BANG);
                push_word($urandom_range(0, 4));
                if ($urandom_range(0, 2) == 0) begin
                    push_byte(ylt_pkg::CH_COLON);
                end
            end else begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end
            // stream may stop in the middle of a line
            if ($urandom_range(0, 29) == 0) begin
                push_end;
                return;
            end
            if ($urandom_range(0, 5) != 0) begin
                repeat ($urandom_range(1, 2)) push_byte(ylt_pkg::CH_SPACE);
            end
        end
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            push_byte(ylt_pkg::CH_LF);
        end else if (roll < 90) begin
            push_byte(ylt_pkg::CH_NUL);
        end else begin
            push_end;
        end
    endtask

    task fill_random(input int target);
        int start;
        start = byte_q.size();
        while (byte_q.size() - start < target) begin
            push_random_line;
        end
    endtask

    // hold off until every request is in and every record has come out
    task wait_drained;
        @(negedge i_clk);
        while (byte_q.size() != 0 || i_s_tvalid || expected_recs.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task check_field(input string name, input logic [11:0] want, input logic [11:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                tokenize(i_s_tdata, i_s_tlast);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = byte_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= next_req[7:0];
                    i_s_tlast  <= next_req[8];
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // record monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_recs.size() == 0) begin
                    $display("%0t: unexpected record, expected none, actual tuser %0d tdata %h",
                             $time, o_m_tuser, o_m_tdata);
                    fail_count++;
                end else begin
                    wanted = expected_recs.pop_front();
                    check_field("token_kind", 12'(wanted.kind), 12'(o_m_tuser));
                    check_field("leading_spaces", 12'(wanted.spaces), 12'(o_m_tdata[7:0]));
                    check_field("start_column", 12'(wanted.column), 12'(o_m_tdata[15:8]));
                    check_field("token_length", wanted.length, o_m_tdata[27:16]);
                    check_field("key_colon", 12'(wanted.colon), 12'(o_m_tdata[28]));
                    check_field("following_byte", 12'(wanted.follow), 12'(o_m_tdata[36:29]));
                    check_field("unclosed_quote", 12'(wanted.unclosed), 12'(o_m_tdata[37]));
                    check_field("tdata_padding", 12'd0,
                                12'(o_m_tdata[ylt_pkg::TDATA_W-1:38]));
                    check_field("last_of_run", 12'(wanted.last), 12'(o_m_tlast));
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // stimulus sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 15;
        recv_idle_pct = 78;
        // empty stream gives file end alone
        push_end;
        // key with dropped colon, bare value at line end
        push_text("  k: v");
        push_byte(ylt_pkg::CH_LF);
        // bracket and brace held for their following byte, zero byte inside a quote
        push_text("[{'a");
        push_byte(ylt_pkg::CH_NUL);
        push_text("b' !t:");
        // stream end with an open tag: token, line end, file end
        push_end;
        // top byte as a bare token ended by a zero byte
        push_byte(8'hff);
        push_byte(ylt_pkg::CH_NUL);
        // quote cut off by stream end
        push_text("'x");
        push_end;
        fill_random(65);
        wait_drained;

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 78;
        recv_idle_pct = 15;
        fill_random(75);
        wait_drained;

        // no idling on either side, long indent for the saturating counts
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (260) push_byte(ylt_pkg::CH_SPACE);
        push_text("abc");
        push_byte(ylt_pkg::CH_LF);
        fill_random(15);
        push_end;
        wait_drained;

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
